// ===== hdl/imhq_pkg.sv =====
`default_nettype none
package imhq_pkg;

    // Operation codes carried in the op field.
    typedef enum logic [1:0] {
        OP_PUSH     = 2'd0,
        OP_POP      = 2'd1,
        OP_DECREASE = 2'd2,
        OP_READ     = 2'd3
    } op_t;

    // Status codes returned with every result word.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_ABSENT    = 3'd3,
        ST_PRESENT   = 3'd4,
        ST_NOT_LOWER = 3'd5
    } status_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POS_WAIT,
        S_DEC_CHECK,
        S_UP_READ,
        S_UP_CMP,
        S_DOWN_READ_L,
        S_DOWN_READ_R,
        S_DOWN_CMP,
        S_PLACE,
        S_READ_WAIT,
        S_POP_WAIT,
        S_LAST_WAIT,
        S_DONE
    } state_t;

    localparam int unsigned ID_WIDTH  = 6;
    localparam int unsigned ID_SPACE  = 64;
    localparam int unsigned POS_WIDTH = 6;

endpackage
`default_nettype wire

// ===== hdl/imhq_ram.sv =====
`default_nettype none
module imhq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/indexed_min_heap_queue.sv =====
`default_nettype none
// Channel  Dir  Handshake               tdata / tuser
// s_axis   in   s_axis_tvalid/tready    {heap_position, key_value, entry_id, op}
// m_axis   out  m_axis_tvalid/tready    {count, out_key, out_id, status}
//
// One word is taken at a time; s_axis_tready is high only in idle with no result waiting.
// A read passes S_DECODE and S_READ_WAIT; a rejected word goes from S_DECODE to S_DONE,
// or from S_DEC_CHECK if a decrease fails its slot check. A push climbs via S_UP_READ and
// S_UP_CMP per level, a decrease too after S_DEC_CHECK; a pop descends per level via
// S_DOWN_READ_L, S_DOWN_READ_R and S_DOWN_CMP (log2 CAPACITY levels at most) unless it
// takes the last entry. rst_n clears the count, presence bits and sequencer at once.
// A stalled result holds in out_reg; s_axis_tready rises in the cycle after it is taken.
module indexed_min_heap_queue #(
    parameter int unsigned CAPACITY  = 64,
    parameter int unsigned KEY_WIDTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // op[1:0], entry_id[7:2], key_value[KEY_WIDTH+7:8], heap_position above
    input  wire logic [((KEY_WIDTH+14+7)/8)*8-1:0] s_axis_tdata,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // status[2:0], out_id[8:3], out_key[KEY_WIDTH+8:9], count above
    output logic      [((KEY_WIDTH+9+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_axis_tdata
);
    localparam int unsigned CW  = $clog2(CAPACITY + 1);
    localparam int unsigned AW  = $clog2(CAPACITY);
    localparam int unsigned IW  = imhq_pkg::ID_WIDTH;
    localparam int unsigned PW  = imhq_pkg::POS_WIDTH;
    localparam int unsigned OUT_W = ((KEY_WIDTH+9+CW+7)/8)*8;

    // Input fields.
    logic [1:0]           in_op;
    logic [IW-1:0]        in_id;
    logic [KEY_WIDTH-1:0] in_key;
    logic [PW-1:0]        in_pos;
    assign in_op  = s_axis_tdata[1:0];
    assign in_id  = s_axis_tdata[7:2];
    assign in_key = s_axis_tdata[KEY_WIDTH+7:8];
    assign in_pos = s_axis_tdata[KEY_WIDTH+13:KEY_WIDTH+8];

    imhq_pkg::state_t state_reg, state_next;
    logic [1:0]           op_reg, op_next;
    logic [IW-1:0]        id_reg, id_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [PW-1:0]        rpos_reg, rpos_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        pos_reg, pos_next;   // current hole, wide for compares
    logic [CW-1:0]        child_reg, child_next;
    logic [KEY_WIDTH-1:0] lkey_reg, lkey_next;
    logic [IW-1:0]        lid_reg, lid_next;
    logic [IW-1:0]        top_id_reg, top_id_next;
    logic [KEY_WIDTH-1:0] top_key_reg, top_key_next;
    logic [imhq_pkg::ID_SPACE-1:0] present_reg, present_next;
    logic [OUT_W-1:0]     out_reg, out_next;
    logic                 ovalid_reg, ovalid_next;

    // Slot and map memory ports.
    logic                 slot_we, map_we;
    logic [AW-1:0]        slot_waddr, slot_raddr;
    logic [KEY_WIDTH+IW-1:0] slot_wdata, slot_rdata;
    logic [IW-1:0]        map_waddr, map_raddr;
    logic [AW-1:0]        map_wdata, map_rdata;
    logic [KEY_WIDTH-1:0] rd_key;
    logic [IW-1:0]        rd_id;
    assign rd_key = slot_rdata[KEY_WIDTH+IW-1:IW];
    assign rd_id  = slot_rdata[IW-1:0];

    imhq_ram #(.WIDTH(KEY_WIDTH + IW), .DEPTH(CAPACITY)) u_slots (
        .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .raddr(slot_raddr), .rdata(slot_rdata)
    );

    imhq_ram #(.WIDTH(AW), .DEPTH(imhq_pkg::ID_SPACE)) u_map (
        .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .raddr(map_raddr), .rdata(map_rdata)
    );

    logic [CW-1:0] parent;
    assign parent = (pos_reg - CW'(1)) >> 1;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= imhq_pkg::S_IDLE;
            cnt_reg     <= '0;
            present_reg <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            present_reg <= present_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        id_reg      <= id_next;
        key_reg     <= key_next;
        rpos_reg    <= rpos_next;
        pos_reg     <= pos_next;
        child_reg   <= child_next;
        lkey_reg    <= lkey_next;
        lid_reg     <= lid_next;
        top_id_reg  <= top_id_next;
        top_key_reg <= top_key_next;
        out_reg     <= out_next;
    end

    // Builds a result word.
    function automatic logic [OUT_W-1:0] pack(input imhq_pkg::status_t st,
        input logic [IW-1:0] oid, input logic [KEY_WIDTH-1:0] okey,
        input logic [CW-1:0] c);
        pack = OUT_W'({c, okey, oid, st});
    endfunction

    // Sequencer: at most one slot memory read and up to two key compares per step.
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        id_next      = id_reg;
        key_next     = key_reg;
        rpos_next    = rpos_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        child_next   = child_reg;
        lkey_next    = lkey_reg;
        lid_next     = lid_reg;
        top_id_next  = top_id_reg;
        top_key_next = top_key_reg;
        present_next = present_reg;
        out_next     = out_reg;
        ovalid_next  = ovalid_reg;
        slot_we      = 1'b0;
        slot_waddr   = pos_reg[AW-1:0];
        slot_wdata   = {key_reg, id_reg};
        slot_raddr   = pos_reg[AW-1:0];
        map_we       = 1'b0;
        map_waddr    = id_reg;
        map_wdata    = pos_reg[AW-1:0];
        map_raddr    = id_reg;
        s_axis_tready = 1'b0;

        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            imhq_pkg::S_IDLE:
            begin
                s_axis_tready = !ovalid_reg;
                if (s_axis_tvalid && !ovalid_reg)
                begin
                    op_next   = in_op;
                    id_next   = in_id;
                    key_next  = in_key;
                    rpos_next = in_pos;
                    state_next = imhq_pkg::S_DECODE;
                end
            end
            imhq_pkg::S_DECODE:
            begin
                case (imhq_pkg::op_t'(op_reg))
                    imhq_pkg::OP_PUSH:
                    begin
                        if (present_reg[id_reg])
                        begin
                            out_next = pack(imhq_pkg::ST_PRESENT, '0, '0, cnt_reg);
                            state_next = imhq_pkg::S_DONE;
                        end
                        else if (cnt_reg >= CW'(CAPACITY))
                        begin
                            out_next = pack(imhq_pkg::ST_FULL, '0, '0, cnt_reg);
                            state_next = imhq_pkg::S_DONE;
                        end
                        else
                        begin
                            pos_next = cnt_reg;
                            cnt_next = cnt_reg + CW'(1);
                            present_next[id_reg] = 1'b1;
                            state_next = imhq_pkg::S_UP_READ;
                        end
                    end
                    imhq_pkg::OP_POP:
                    begin
                        if (cnt_reg == '0)
                        begin
                            out_next = pack(imhq_pkg::ST_EMPTY, '0, '0, cnt_reg);
                            state_next = imhq_pkg::S_DONE;
                        end
                        else
                        begin
                            slot_raddr = '0;
                            state_next = imhq_pkg::S_POP_WAIT;
                        end
                    end
                    imhq_pkg::OP_DECREASE:
                    begin
                        if (!present_reg[id_reg])
                        begin
                            out_next = pack(imhq_pkg::ST_ABSENT, '0, '0, cnt_reg);
                            state_next = imhq_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = imhq_pkg::S_POS_WAIT;
                        end
                    end
                    default:
                    begin
                        if (CW'(rpos_reg) >= cnt_reg)
                        begin
                            out_next = pack(imhq_pkg::ST_EMPTY, '0, '0, cnt_reg);
                            state_next = imhq_pkg::S_DONE;
                        end
                        else
                        begin
                            slot_raddr = AW'(rpos_reg);
                            state_next = imhq_pkg::S_READ_WAIT;
                        end
                    end
                endcase
            end
            imhq_pkg::S_READ_WAIT:
            begin
                out_next = pack(imhq_pkg::ST_OK, rd_id, rd_key, cnt_reg);
                state_next = imhq_pkg::S_DONE;
            end
            imhq_pkg::S_POS_WAIT:
            begin
                // Map data is valid; fetch the slot it names.
                pos_next   = CW'(map_rdata);
                slot_raddr = map_rdata;
                state_next = imhq_pkg::S_DEC_CHECK;
            end
            imhq_pkg::S_DEC_CHECK:
            begin
                if (pos_reg >= cnt_reg)
                begin
                    out_next = pack(imhq_pkg::ST_ABSENT, '0, '0, cnt_reg);
                    state_next = imhq_pkg::S_DONE;
                end
                else if (key_reg >= rd_key)
                begin
                    out_next = pack(imhq_pkg::ST_NOT_LOWER, '0, '0, cnt_reg);
                    state_next = imhq_pkg::S_DONE;
                end
                else
                begin
                    state_next = imhq_pkg::S_UP_READ;
                end
            end
            imhq_pkg::S_UP_READ:
            begin
                if (pos_reg == '0)
                begin
                    state_next = imhq_pkg::S_PLACE;
                end
                else
                begin
                    slot_raddr = parent[AW-1:0];
                    state_next = imhq_pkg::S_UP_CMP;
                end
            end
            imhq_pkg::S_UP_CMP:
            begin
                if (rd_key > key_reg)
                begin
                    // Parent moves down into the hole.
                    slot_we    = 1'b1;
                    slot_wdata = slot_rdata;
                    map_we     = 1'b1;
                    map_waddr  = rd_id;
                    pos_next   = parent;
                    state_next = imhq_pkg::S_UP_READ;
                end
                else
                begin
                    state_next = imhq_pkg::S_PLACE;
                end
            end
            imhq_pkg::S_POP_WAIT:
            begin
                top_id_next  = rd_id;
                top_key_next = rd_key;
                present_next[rd_id] = 1'b0;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    out_next = pack(imhq_pkg::ST_OK, rd_id, rd_key, '0);
                    state_next = imhq_pkg::S_DONE;
                end
                else
                begin
                    slot_raddr = AW'(cnt_reg - CW'(1));
                    state_next = imhq_pkg::S_LAST_WAIT;
                end
            end
            imhq_pkg::S_LAST_WAIT:
            begin
                key_next = rd_key;
                id_next  = rd_id;
                pos_next = '0;
                state_next = imhq_pkg::S_DOWN_READ_L;
            end
            imhq_pkg::S_DOWN_READ_L:
            begin
                child_next = {pos_reg[CW-2:0], 1'b1};
                if ({pos_reg, 1'b1} >= {1'b0, cnt_reg})
                begin
                    state_next = imhq_pkg::S_PLACE;
                end
                else
                begin
                    slot_raddr = AW'({pos_reg[CW-2:0], 1'b1});
                    state_next = imhq_pkg::S_DOWN_READ_R;
                end
            end
            imhq_pkg::S_DOWN_READ_R:
            begin
                lkey_next = rd_key;
                lid_next  = rd_id;
                if (child_reg + CW'(1) < cnt_reg)
                begin
                    slot_raddr = AW'(child_reg + CW'(1));
                    state_next = imhq_pkg::S_DOWN_CMP;
                end
                else
                begin
                    // Only a left child: decide now.
                    if (key_reg <= rd_key)
                    begin
                        state_next = imhq_pkg::S_PLACE;
                    end
                    else
                    begin
                        slot_we    = 1'b1;
                        slot_wdata = slot_rdata;
                        map_we     = 1'b1;
                        map_waddr  = rd_id;
                        pos_next   = child_reg;
                        state_next = imhq_pkg::S_DOWN_READ_L;
                    end
                end
            end
            imhq_pkg::S_DOWN_CMP:
            begin
                if (lkey_reg > rd_key)
                begin
                    if (key_reg <= rd_key)
                    begin
                        state_next = imhq_pkg::S_PLACE;
                    end
                    else
                    begin
                        slot_we    = 1'b1;
                        slot_wdata = slot_rdata;
                        map_we     = 1'b1;
                        map_waddr  = rd_id;
                        pos_next   = child_reg + CW'(1);
                        state_next = imhq_pkg::S_DOWN_READ_L;
                    end
                end
                else if (key_reg <= lkey_reg)
                begin
                    state_next = imhq_pkg::S_PLACE;
                end
                else
                begin
                    slot_we    = 1'b1;
                    slot_wdata = {lkey_reg, lid_reg};
                    map_we     = 1'b1;
                    map_waddr  = lid_reg;
                    pos_next   = child_reg;
                    state_next = imhq_pkg::S_DOWN_READ_L;
                end
            end
            imhq_pkg::S_PLACE:
            begin
                // Moving entry lands in the hole.
                slot_we = 1'b1;
                map_we  = 1'b1;
                if (imhq_pkg::op_t'(op_reg) == imhq_pkg::OP_POP)
                begin
                    out_next = pack(imhq_pkg::ST_OK, top_id_reg, top_key_reg, cnt_reg);
                end
                else
                begin
                    out_next = pack(imhq_pkg::ST_OK, '0, '0, cnt_reg);
                end
                state_next = imhq_pkg::S_DONE;
            end
            imhq_pkg::S_DONE:
            begin
                ovalid_next = 1'b1;
                state_next  = imhq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = imhq_pkg::S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = out_reg;

    // The count never exceeds capacity.
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // Input is never taken while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> !s_axis_tready)
        else $error("input taken while result pending");

    // A result appears only after the done step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg) == imhq_pkg::S_DONE)
        else $error("result raised outside done step");

    // In idle the presence bits match the held entries in number.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == imhq_pkg::S_IDLE |-> $countones(present_reg) == int'(cnt_reg))
        else $error("presence bits disagree with count");

endmodule
`default_nettype wire
